### design/qnfas_pkg.sv
`timescale 1ns / 1ps

package qnfas_pkg;

    localparam int LANE_COUNT   = 4;
    localparam int ADDRESS_BITS = 28;
    localparam int LANE_IDX_W   = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int BUS_LANES    = 4;

    // Command codes
    localparam logic [7:0] CMD_READ_A    = 8'h00;
    localparam logic [7:0] CMD_READ_B    = 8'h01;
    localparam logic [7:0] CMD_READ_C    = 8'h50;
    localparam logic [7:0] CMD_READ_ID   = 8'h90;
    localparam logic [7:0] CMD_RESET     = 8'hff;
    localparam logic [7:0] CMD_PROG      = 8'h80;
    localparam logic [7:0] CMD_ERASE     = 8'h60;
    localparam logic [7:0] CMD_STATUS    = 8'h70;
    localparam logic [7:0] CMD_PROG_GO   = 8'h10;
    localparam logic [7:0] CMD_ERASE_GO  = 8'hd0;
    localparam logic [7:0] CMD_INVALID   = 8'hff;

    // Address scale factors and read offsets
    localparam logic [39:0] SCALE_LOW   = 40'd4;
    localparam logic [39:0] SCALE_MID   = 40'h840;
    localparam logic [39:0] SCALE_HIGH  = 40'h84000;
    localparam logic [39:0] OFFSET_B    = 40'd1024;
    localparam logic [39:0] OFFSET_C    = 40'd2048;
    localparam logic [39:0] OFFSET_STEP = 40'd4;

    typedef logic [ADDRESS_BITS-1:0] t_addr;
    typedef logic [LANE_COUNT-1:0][ADDRESS_BITS-1:0] t_addr_vec;
    typedef logic [LANE_COUNT-1:0] t_lane_mask;

    typedef enum logic [1:0] {
        MODE_CMD  = 2'd0,
        MODE_ADDR = 2'd1,
        MODE_READ = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ASTEP_LOW  = 2'd0,
        ASTEP_MID  = 2'd1,
        ASTEP_HIGH = 2'd2,
        ASTEP_DONE = 2'd3
    } t_addr_step;

    typedef struct packed {
        logic       cmd_wr;
        logic       addr_wr;
        logic       rd;
        t_addr_step step;
    } t_lane_ctrl;

    function automatic logic is_known_cmd(input logic [7:0] b);
        logic known;
        known = (b == CMD_READ_A)  || (b == CMD_READ_B)  || (b == CMD_READ_C) ||
                (b == CMD_READ_ID) || (b == CMD_RESET)   || (b == CMD_PROG)   ||
                (b == CMD_ERASE)   || (b == CMD_STATUS)  || (b == CMD_PROG_GO) ||
                (b == CMD_ERASE_GO);
        return known;
    endfunction

    // Scale a lane byte by a constant, wrapped to the address width
    function automatic t_addr scale_byte(input logic [7:0] b, input logic [39:0] k);
        logic [39:0] prod;
        prod = {32'd0, b} * k;
        return prod[ADDRESS_BITS-1:0];
    endfunction

endpackage

### design/qnfas_lane.sv
`timescale 1ns / 1ps

module qnfas_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  qnfas_pkg::t_lane_ctrl               i_ctrl,
    input  logic [7:0]                          i_byte,
    input  logic [qnfas_pkg::LANE_IDX_W-1:0]    i_lane_idx,
    output qnfas_pkg::t_addr                    o_byte_address,
    output logic                                o_reading
);

    logic [7:0]       r_cmd,    n_cmd;
    qnfas_pkg::t_addr r_offset, n_offset;
    qnfas_pkg::t_addr r_base,   n_base;
    qnfas_pkg::t_addr w_lane_add;
    logic [7:0]       w_cmd_in;

    // Report the current array byte address and read status
    assign w_lane_add     = qnfas_pkg::t_addr'(i_lane_idx);
    assign o_byte_address = r_base + r_offset + w_lane_add;
    assign o_reading      = (r_cmd <= qnfas_pkg::CMD_READ_C);

    assign w_cmd_in = qnfas_pkg::is_known_cmd(i_byte) ? i_byte : qnfas_pkg::CMD_INVALID;

    // Latch command, preset offset on read commands, advance it on data reads
    always_comb begin
        n_cmd    = r_cmd;
        n_offset = r_offset;
        if (i_ctrl.cmd_wr) begin
            n_cmd = w_cmd_in;
            if (w_cmd_in == qnfas_pkg::CMD_READ_A) begin
                n_offset = '0;
            end else if (w_cmd_in == qnfas_pkg::CMD_READ_B) begin
                n_offset = qnfas_pkg::OFFSET_B[qnfas_pkg::ADDRESS_BITS-1:0];
            end else if (w_cmd_in == qnfas_pkg::CMD_READ_C) begin
                n_offset = qnfas_pkg::OFFSET_C[qnfas_pkg::ADDRESS_BITS-1:0];
            end
        end else if (i_ctrl.rd && o_reading) begin
            n_offset = r_offset + qnfas_pkg::OFFSET_STEP[qnfas_pkg::ADDRESS_BITS-1:0];
        end
    end

    // Accumulate the interleaved base address one step per address write
    always_comb begin
        n_base = r_base;
        if (i_ctrl.addr_wr) begin
            unique case (i_ctrl.step)
                qnfas_pkg::ASTEP_LOW: begin
                    n_base = qnfas_pkg::scale_byte(i_byte, qnfas_pkg::SCALE_LOW);
                end
                qnfas_pkg::ASTEP_MID: begin
                    n_base = r_base + qnfas_pkg::scale_byte(i_byte, qnfas_pkg::SCALE_MID);
                end
                qnfas_pkg::ASTEP_HIGH: begin
                    n_base = r_base + qnfas_pkg::scale_byte(i_byte, qnfas_pkg::SCALE_HIGH);
                end
                default: begin
                    n_base = r_base;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= '0;
            r_offset <= '0;
            r_base   <= '0;
        end else begin
            r_cmd    <= n_cmd;
            r_offset <= n_offset;
            r_base   <= n_base;
        end
    end

endmodule

### design/qnfas_merge.sv
`timescale 1ns / 1ps

module qnfas_merge (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  qnfas_pkg::t_addr_vec    i_addr,
    input  qnfas_pkg::t_lane_mask   i_mask,
    output logic                    o_full,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output qnfas_pkg::t_addr_vec    o_addr,
    output qnfas_pkg::t_lane_mask   o_mask
);

    logic                  r_out_valid, n_out_valid;
    logic                  r_skid_valid, n_skid_valid;
    qnfas_pkg::t_addr_vec  r_out_addr, n_out_addr;
    qnfas_pkg::t_lane_mask r_out_mask, n_out_mask;
    qnfas_pkg::t_addr_vec  r_skid_addr, n_skid_addr;
    qnfas_pkg::t_lane_mask r_skid_mask, n_skid_mask;
    logic                  w_pop;

    assign w_pop       = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_addr      = r_out_addr;
    assign o_mask      = r_out_mask;

    // Move items through the output register and the skid stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_addr   = r_out_addr;
        n_out_mask   = r_out_mask;
        n_skid_addr  = r_skid_addr;
        n_skid_mask  = r_skid_mask;
        if (r_skid_valid) begin
            if (w_pop) begin
                n_out_addr   = r_skid_addr;
                n_out_mask   = r_skid_mask;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                n_out_valid = 1'b1;
                n_out_addr  = i_addr;
                n_out_mask  = i_mask;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_addr  = i_addr;
                n_skid_mask  = i_mask;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_addr  <= n_out_addr;
        r_out_mask  <= n_out_mask;
        r_skid_addr <= n_skid_addr;
        r_skid_mask <= n_skid_mask;
    end

    // The skid stage only fills behind a held output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage valid with empty output register");

    // A push into an empty buffer shows up at the output next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_out_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("pushed item did not land in output register");

endmodule

### design/quad_nand_flash_address_sequencer.sv
`timescale 1ns / 1ps

// Four byte-wide NAND flash lanes on a 32-bit bus: command and address sequencer.
// Input channel (i_in_valid / o_in_stall) takes one bus access per item:
// i_mode selects command write, address write or data read; byte n of
// i_bus_data belongs to lane n. Writes update the per-lane registers and
// produce no result. A data read produces one result item on the output
// channel (o_out_valid / i_out_stall): each lane's array byte address and
// the mask of lanes returning array data (others return status).
// A read result is valid the cycle after acceptance if the output register is empty.
// Throughput: one item per cycle while o_in_stall is low; the lanes compute
// in parallel and the result goes into a two-entry output buffer (output
// register plus skid). When the receiver stalls, the buffer holds results
// unchanged; o_in_stall rises only once both entries are full, and drops
// the cycle after the output item is taken.
// Reset (synchronous, i_rst_n low) clears all lane commands, offsets and
// base addresses, the address step counter and the output buffer.

module quad_nand_flash_address_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_mode,
    input  logic [31:0]                          i_bus_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [qnfas_pkg::ADDRESS_BITS-1:0]   o_lane0_byte_address,
    output logic [qnfas_pkg::ADDRESS_BITS-1:0]   o_lane1_byte_address,
    output logic [qnfas_pkg::ADDRESS_BITS-1:0]   o_lane2_byte_address,
    output logic [qnfas_pkg::ADDRESS_BITS-1:0]   o_lane3_byte_address,
    output logic [qnfas_pkg::LANE_COUNT-1:0]     o_lanes_reading
);

    qnfas_pkg::t_addr_step r_step, n_step;
    qnfas_pkg::t_lane_ctrl w_ctrl;
    qnfas_pkg::t_addr_vec  w_lane_addr;
    qnfas_pkg::t_lane_mask w_lane_reading;
    qnfas_pkg::t_addr_vec  w_out_addr;
    logic                  w_full;
    logic                  w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    // Decode the accepted item into lane controls
    always_comb begin
        w_ctrl.cmd_wr  = w_accept && (i_mode == qnfas_pkg::MODE_CMD);
        w_ctrl.addr_wr = w_accept && (i_mode == qnfas_pkg::MODE_ADDR)
                         && (r_step != qnfas_pkg::ASTEP_DONE);
        w_ctrl.rd      = w_accept && (i_mode == qnfas_pkg::MODE_READ);
        w_ctrl.step    = r_step;
    end

    // Restart on command write, advance on address write, saturate
    always_comb begin
        n_step = r_step;
        if (w_ctrl.cmd_wr) begin
            n_step = qnfas_pkg::ASTEP_LOW;
        end else if (w_ctrl.addr_wr) begin
            unique case (r_step)
                qnfas_pkg::ASTEP_LOW:  n_step = qnfas_pkg::ASTEP_MID;
                qnfas_pkg::ASTEP_MID:  n_step = qnfas_pkg::ASTEP_HIGH;
                qnfas_pkg::ASTEP_HIGH: n_step = qnfas_pkg::ASTEP_DONE;
                default:               n_step = qnfas_pkg::ASTEP_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= qnfas_pkg::ASTEP_LOW;
        end else begin
            r_step <= n_step;
        end
    end

    // Lane cores
    genvar g;
    generate
        for (g = 0; g < qnfas_pkg::LANE_COUNT; g++) begin : g_lane
            logic [7:0] w_byte;
            if (g < qnfas_pkg::BUS_LANES) begin : g_bus
                assign w_byte = i_bus_data[8*g +: 8];
            end else begin : g_nobus
                assign w_byte = 8'd0;
            end
            qnfas_lane u_lane (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (w_ctrl),
                .i_byte         (w_byte),
                .i_lane_idx     (qnfas_pkg::LANE_IDX_W'(g)),
                .o_byte_address (w_lane_addr[g]),
                .o_reading      (w_lane_reading[g])
            );
        end
    endgenerate

    // Merge lane results into the output buffer
    qnfas_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_ctrl.rd),
        .i_addr      (w_lane_addr),
        .i_mask      (w_lane_reading),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_addr      (w_out_addr),
        .o_mask      (o_lanes_reading)
    );

    assign o_lane0_byte_address = w_out_addr[0];
    assign o_lane1_byte_address = w_out_addr[1];
    assign o_lane2_byte_address = w_out_addr[2];
    assign o_lane3_byte_address = w_out_addr[3];

    // A command write always restarts the address phase
    a_cmd_restarts_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_mode == qnfas_pkg::MODE_CMD)) |=> (r_step == qnfas_pkg::ASTEP_LOW))
        else $error("address step not restarted by command write");

    // The step counter stays put when no write is accepted
    a_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_ctrl.cmd_wr && !w_ctrl.addr_wr) |=> $stable(r_step))
        else $error("address step moved without a write");

    // Address writes in the last step saturate the counter
    a_step_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == qnfas_pkg::ASTEP_DONE && !w_ctrl.cmd_wr)
        |=> (r_step == qnfas_pkg::ASTEP_DONE))
        else $error("address step left its saturated value");

endmodule
